### rtl/core/rotenc_pkg.sv
package rotenc_pkg;

  // default build widths
  localparam int VALUE_WIDTH_DEF    = 16;
  localparam int DEBOUNCE_WIDTH_DEF = 11;

  // fixed field widths
  localparam int FIELD_W     = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int STEP_W      = 10;
  localparam int DETENT_W    = 6;
  localparam int DEBMS_W     = 10;
  localparam int POS_W       = 7;
  localparam int POS_LIMIT   = 63;

  // register reset values
  localparam logic                  LIST_MODE_RST    = 1'b0;
  localparam logic [CFG_DATA_W-1:0] VALUE_LOW_RST    = 16'd0;
  localparam logic [CFG_DATA_W-1:0] VALUE_HIGH_RST   = 16'd255;
  localparam logic [STEP_W-1:0]     VALUE_STEP_RST   = 10'd1;
  localparam logic [DETENT_W-1:0]   DETENT_COUNT_RST = 6'd4;
  localparam logic [DEBMS_W-1:0]    DEBOUNCE_MS_RST  = 10'd50;
  localparam logic                  BUTTON_LEVEL_RST = 1'b0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_LIST_MODE    = 3'd0,
    CFG_VALUE_LOW    = 3'd1,
    CFG_VALUE_HIGH   = 3'd2,
    CFG_VALUE_STEP   = 3'd3,
    CFG_START_VALUE  = 3'd4,
    CFG_DETENT_COUNT = 3'd5,
    CFG_DEBOUNCE_MS  = 3'd6,
    CFG_BUTTON_LEVEL = 3'd7
  } cfg_reg_t;

  // detent move request toward the value update
  typedef struct packed {
    logic list_mode;
    logic up;
    logic down;
    logic pulse;
  } move_t;

  // quadrature step from previous {a,b} to current {a,b}
  function automatic logic signed [1:0] quad_delta(input logic [1:0] from_ab,
                                                   input logic [1:0] to_ab);
    logic signed [1:0] d;
    d = 2'sd0;
    unique case ({from_ab, to_ab})
      4'b1001, 4'b0110, 4'b0010, 4'b1101: d = -2'sd1;
      4'b0011, 4'b1100, 4'b1000, 4'b0111: d = 2'sd1;
      default:                            d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

### rtl/core/rotenc_sample_if.sv
interface rotenc_sample_if;
  logic valid;
  logic ready;
  logic pin_a;
  logic pin_b;
  logic button_raw;

  modport source(output valid, output pin_a, output pin_b, output button_raw,
                 input ready);
  modport sink(input valid, input pin_a, input pin_b, input button_raw,
               output ready);
endinterface

### rtl/core/rotenc_result_if.sv
interface rotenc_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rotenc_pkg::FIELD_W-1:0] current_value;
  logic                                 changed;
  logic                                 select_pulse;
  logic                                 button_down;

  modport source(output valid, output current_value, output changed,
                 output select_pulse, output button_down, input ready);
  modport sink(input valid, input current_value, input changed,
               input select_pulse, input button_down, output ready);
endinterface

### rtl/core/rotenc_value_calc.sv
module rotenc_value_calc #(
  parameter int VALUE_WIDTH = rotenc_pkg::VALUE_WIDTH_DEF
) (
  input  logic signed [VALUE_WIDTH-1:0]            value_now,
  input  logic        [rotenc_pkg::STEP_W-1:0]     value_step,
  input  logic signed [rotenc_pkg::CFG_DATA_W-1:0] value_low,
  input  logic signed [rotenc_pkg::CFG_DATA_W-1:0] value_high,
  input  rotenc_pkg::move_t                        move,
  output logic signed [VALUE_WIDTH-1:0]            value_next,
  output logic                                     changed
);

  // wide enough for any value plus or minus a step, and for the limits
  localparam int CW = ((VALUE_WIDTH > rotenc_pkg::CFG_DATA_W) ?
                       VALUE_WIDTH : rotenc_pkg::CFG_DATA_W) + 2;

  logic signed [CW-1:0] vx, stepx, lowx, highx, delta, v1, v2, v3;
  logic                 below, above;

  always_comb begin
    vx    = CW'(value_now);
    stepx = CW'(value_step);
    lowx  = CW'(value_low);
    highx = CW'(value_high);

    // value mode turns the other way and moves by step
    delta = '0;
    if (move.list_mode) begin
      if (move.up)   delta = CW'(1);
      if (move.down) delta = -CW'(1);
    end else begin
      if (move.up)   delta = -stepx;
      if (move.down) delta = stepx;
    end
    v1 = vx + delta;

    below   = 1'b0;
    above   = 1'b0;
    v2      = v1;
    v3      = v1;
    changed = 1'b0;
    if (!move.list_mode) begin
      // clamp every sample, low first then high
      below   = (v1 < lowx);
      v2      = below ? lowx : v1;
      above   = (v2 > highx);
      v3      = above ? highx : v2;
      changed = move.up | move.down | below | above;
    end else if (move.up || move.down || move.pulse) begin
      // clamp only on a detent or press, high first then low
      above   = (v1 > highx);
      v2      = above ? highx : v1;
      below   = (v2 < lowx);
      v3      = below ? lowx : v2;
      changed = 1'b1;
    end

    value_next = v3[VALUE_WIDTH-1:0];
  end

endmodule

### rtl/core/rotary_encoder_value_entry_core.sv
// channel   | dir | payload                                         | accepted when
// ----------+-----+-------------------------------------------------+--------------
// samples   | in  | pin_a, pin_b, button_raw                        | valid & ready
// results   | out | current_value, changed, select_pulse, button_down | valid & ready
// cfg       | in  | cfg_index, cfg_data                             | cfg_write
//
// one item per cycle sustained while results are not stalled; a result is registered
// through the sample register, then the result register, and the decode/debounce/value update
// between them is combinational, so the position-to-clamp path sets the clock
// rst is synchronous and active high: state and registers return to their defaults
// a stalled result holds; the sample register keeps taking items while the result
// register drains, and samples.ready drops only when both hold an item and the
// result is stalled

module rotary_encoder_value_entry_core #(
  parameter int VALUE_WIDTH    = rotenc_pkg::VALUE_WIDTH_DEF,
  parameter int DEBOUNCE_WIDTH = rotenc_pkg::DEBOUNCE_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  rotenc_sample_if.sink                          samples,
  rotenc_result_if.source                        results,
  input  logic                                   cfg_write,
  input  logic [rotenc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [rotenc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // width covering both the stored value and 16-bit fields
  localparam int XW = (VALUE_WIDTH > rotenc_pkg::CFG_DATA_W) ?
                      VALUE_WIDTH : rotenc_pkg::CFG_DATA_W;
  // width for comparing the stable count against debounce_ms
  localparam int MW = (DEBOUNCE_WIDTH > rotenc_pkg::DEBMS_W) ?
                      DEBOUNCE_WIDTH : rotenc_pkg::DEBMS_W;
  localparam int PW = rotenc_pkg::POS_W;

  // configuration registers
  logic                                    list_mode;
  logic signed [rotenc_pkg::CFG_DATA_W-1:0] value_low;
  logic signed [rotenc_pkg::CFG_DATA_W-1:0] value_high;
  logic        [rotenc_pkg::STEP_W-1:0]     value_step;
  logic        [rotenc_pkg::DETENT_W-1:0]   detent_count;
  logic        [rotenc_pkg::DEBMS_W-1:0]    debounce_ms;
  logic                                    button_level;

  // per-sample state
  logic                           prev_a, prev_b;
  logic signed [PW-1:0]           position;
  logic                           last_raw;
  logic [DEBOUNCE_WIDTH-1:0]      stable_count;
  logic                           debounced;
  logic signed [VALUE_WIDTH-1:0]  value_now;

  // sample register
  logic s1_valid, s1_a, s1_b, s1_raw;

  // result register
  logic                                     res_valid;
  logic signed [rotenc_pkg::FIELD_W-1:0]    res_value;
  logic                                     res_changed, res_pulse, res_down;

  logic advance, take;

  // result register frees up when empty or when its item is taken this edge
  assign advance       = !res_valid || results.ready;
  assign take          = s1_valid && advance;
  assign samples.ready = !s1_valid || advance;

  // ---------------- quadrature decode and detent ----------------
  logic signed [1:0]    quad;
  logic signed [PW:0]   pos_sum, pos_sat, det_x, pos_adj;
  logic                 det_up, det_down;
  logic signed [PW-1:0] position_next;

  always_comb begin
    quad    = rotenc_pkg::quad_delta({prev_a, prev_b}, {s1_a, s1_b});
    pos_sum = (PW+1)'(position) + (PW+1)'(quad);
    // saturate at the position limits
    if (pos_sum > (PW+1)'(rotenc_pkg::POS_LIMIT)) begin
      pos_sat = (PW+1)'(rotenc_pkg::POS_LIMIT);
    end else if (pos_sum < -(PW+1)'(rotenc_pkg::POS_LIMIT)) begin
      pos_sat = -(PW+1)'(rotenc_pkg::POS_LIMIT);
    end else begin
      pos_sat = pos_sum;
    end
    // a zero detent count never fires
    det_x    = (PW+1)'({1'b0, detent_count});
    det_up   = (detent_count != '0) && (pos_sat >= det_x);
    det_down = (detent_count != '0) && !det_up && (pos_sat <= -det_x);
    if (det_up) begin
      pos_adj = pos_sat - det_x;
    end else if (det_down) begin
      pos_adj = pos_sat + det_x;
    end else begin
      pos_adj = pos_sat;
    end
    position_next = pos_adj[PW-1:0];
  end

  // ---------------- button debounce ----------------
  logic [DEBOUNCE_WIDTH-1:0] stable_count_next;
  logic                      debounced_next, pulse;

  always_comb begin
    if (s1_raw != last_raw) begin
      stable_count_next = '0;
    end else if (stable_count != '1) begin
      stable_count_next = stable_count + DEBOUNCE_WIDTH'(1);
    end else begin
      stable_count_next = stable_count;
    end
    debounced_next = debounced;
    pulse          = 1'b0;
    // decision uses the level held before this sample
    if (MW'(stable_count_next) > MW'(debounce_ms)) begin
      if (last_raw == button_level) begin
        pulse          = !debounced;
        debounced_next = 1'b1;
      end else begin
        debounced_next = 1'b0;
      end
    end
  end

  // ---------------- value update ----------------
  rotenc_pkg::move_t              move;
  logic signed [VALUE_WIDTH-1:0]  value_next;
  logic                           value_changed;
  logic signed [XW-1:0]           value_ext, start_ext;

  assign move.list_mode = list_mode;
  assign move.up        = det_up;
  assign move.down      = det_down;
  assign move.pulse     = pulse;

  rotenc_value_calc #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_value_calc (
    .value_now (value_now),
    .value_step(value_step),
    .value_low (value_low),
    .value_high(value_high),
    .move      (move),
    .value_next(value_next),
    .changed   (value_changed)
  );

  // narrow values sign-extend onto the 16-bit field, wide ones truncate
  assign value_ext = XW'(value_next);
  assign start_ext = XW'($signed(cfg_data));

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.ready) begin
      s1_valid <= samples.valid;
    end
    if (samples.valid && samples.ready) begin
      s1_a   <= samples.pin_a;
      s1_b   <= samples.pin_b;
      s1_raw <= samples.button_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
    if (take) begin
      res_value   <= value_ext[rotenc_pkg::FIELD_W-1:0];
      res_changed <= value_changed;
      res_pulse   <= pulse;
      res_down    <= debounced_next;
    end
  end

  // state and configuration; start_value writes load the value directly
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_a       <= 1'b0;
      prev_b       <= 1'b0;
      position     <= '0;
      last_raw     <= 1'b0;
      stable_count <= '0;
      debounced    <= 1'b0;
      value_now    <= '0;
      list_mode    <= rotenc_pkg::LIST_MODE_RST;
      value_low    <= rotenc_pkg::VALUE_LOW_RST;
      value_high   <= rotenc_pkg::VALUE_HIGH_RST;
      value_step   <= rotenc_pkg::VALUE_STEP_RST;
      detent_count <= rotenc_pkg::DETENT_COUNT_RST;
      debounce_ms  <= rotenc_pkg::DEBOUNCE_MS_RST;
      button_level <= rotenc_pkg::BUTTON_LEVEL_RST;
    end else begin
      if (take) begin
        prev_a       <= s1_a;
        prev_b       <= s1_b;
        position     <= position_next;
        last_raw     <= s1_raw;
        stable_count <= stable_count_next;
        debounced    <= debounced_next;
        value_now    <= value_next;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          rotenc_pkg::CFG_LIST_MODE:    list_mode    <= cfg_data[0];
          rotenc_pkg::CFG_VALUE_LOW:    value_low    <= cfg_data;
          rotenc_pkg::CFG_VALUE_HIGH:   value_high   <= cfg_data;
          rotenc_pkg::CFG_VALUE_STEP:   value_step   <= cfg_data[rotenc_pkg::STEP_W-1:0];
          rotenc_pkg::CFG_START_VALUE:  value_now    <= start_ext[VALUE_WIDTH-1:0];
          rotenc_pkg::CFG_DETENT_COUNT: detent_count <= cfg_data[rotenc_pkg::DETENT_W-1:0];
          rotenc_pkg::CFG_DEBOUNCE_MS:  debounce_ms  <= cfg_data[rotenc_pkg::DEBMS_W-1:0];
          rotenc_pkg::CFG_BUTTON_LEVEL: button_level <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  assign results.valid         = res_valid;
  assign results.current_value = res_value;
  assign results.changed       = res_changed;
  assign results.select_pulse  = res_pulse;
  assign results.button_down   = res_down;

`ifndef SYNTHESIS
  // position stays inside the saturation limits
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (position <= PW'(rotenc_pkg::POS_LIMIT)) && (position >= -PW'(rotenc_pkg::POS_LIMIT)))
    else $error("position outside saturation range");

  // a select pulse only comes with a pressed debounced state
  a_pulse_down: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.select_pulse) |-> results.button_down)
    else $error("select pulse without button down");

  // a pending result leaves only through a handshake
  a_res_drain: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !results.ready) |=> res_valid)
    else $error("result dropped while stalled");

  // no sample is processed into a result slot that is still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    take |-> (!res_valid || results.ready))
    else $error("result register overwritten");
`endif

endmodule

### dv/rotary_encoder_value_entry_check.sv
`timescale 1ns / 100ps

module rotary_encoder_value_entry_check
  import rotenc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  rotenc_sample_if               samples,
  rotenc_result_if               results,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     waiting
);

  typedef struct packed {
    logic signed [FIELD_W-1:0] value;
    logic                      changed;
    logic                      select;
    logic                      held;
  } knob_out_t;

  knob_out_t knob_q[$];
  int mismatches = 0;
  int queued = 0;

  assign fail_count = mismatches;
  assign waiting    = queued;

  // register copies
  logic                         list_nav;
  logic signed [CFG_DATA_W-1:0] floor_val;
  logic signed [CFG_DATA_W-1:0] ceil_val;
  logic [STEP_W-1:0]            step_amt;
  logic [DETENT_W-1:0]          counts_per_detent;
  logic [DEBMS_W-1:0]           settle_ms;
  logic                         press_level;

  // knob state
  logic [1:0]                        last_ab;
  int                                quad_pos;
  logic                              last_btn;
  logic [DEBOUNCE_WIDTH_DEF-1:0]     stable_ms;
  logic                              btn_state;
  logic signed [VALUE_WIDTH_DEF-1:0] knob_value;

  task automatic clear_knob();
    list_nav          = LIST_MODE_RST;
    floor_val         = VALUE_LOW_RST;
    ceil_val          = VALUE_HIGH_RST;
    step_amt          = VALUE_STEP_RST;
    counts_per_detent = DETENT_COUNT_RST;
    settle_ms         = DEBOUNCE_MS_RST;
    press_level       = BUTTON_LEVEL_RST;
    last_ab           = 2'b00;
    quad_pos          = 0;
    last_btn          = 1'b0;
    stable_ms         = '0;
    btn_state         = 1'b0;
    knob_value        = '0;
  endtask

  task automatic take_write(input logic [CFG_INDEX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_LIST_MODE:    list_nav = data[0];
      CFG_VALUE_LOW:    floor_val = data;
      CFG_VALUE_HIGH:   ceil_val = data;
      CFG_VALUE_STEP:   step_amt = data[STEP_W-1:0];
      CFG_START_VALUE:  knob_value = data;
      CFG_DETENT_COUNT: counts_per_detent = data[DETENT_W-1:0];
      CFG_DEBOUNCE_MS:  settle_ms = data[DEBMS_W-1:0];
      CFG_BUTTON_LEVEL: press_level = data[0];
      default: ;
    endcase
  endtask

  // signed count for one pin change, zero for the skipped ones
  function automatic int quad_count(input logic [1:0] from_ab, input logic [1:0] to_ab);
    case ({from_ab, to_ab})
      {2'b10, 2'b01}, {2'b01, 2'b10}, {2'b00, 2'b10}, {2'b11, 2'b01}: return -1;
      {2'b00, 2'b11}, {2'b11, 2'b00}, {2'b10, 2'b00}, {2'b01, 2'b11}: return 1;
      default: return 0;
    endcase
  endfunction

  task automatic knob_sample(input logic a, input logic b, input logic raw,
                             output knob_out_t res);
    int   lo, hi, v, det, stp;
    logic up, dn, pulse, touched;
    lo      = floor_val;
    hi      = ceil_val;
    v       = knob_value;
    det     = counts_per_detent;
    stp     = step_amt;
    up      = 1'b0;
    dn      = 1'b0;
    pulse   = 1'b0;
    touched = 1'b0;

    if ({a, b} != last_ab) begin
      quad_pos += quad_count(last_ab, {a, b});
      if (quad_pos > POS_LIMIT) quad_pos = POS_LIMIT;
      if (quad_pos < -POS_LIMIT) quad_pos = -POS_LIMIT;
      last_ab = {a, b};
    end

    if (raw != last_btn) stable_ms = '0;
    else if (stable_ms != '1) stable_ms = stable_ms + 1'b1;
    if (stable_ms > settle_ms) begin
      if (last_btn == press_level) begin
        pulse     = !btn_state;
        btn_state = 1'b1;
      end else begin
        btn_state = 1'b0;
      end
    end
    last_btn = raw;

    if (det > 0) begin
      if (quad_pos >= det) begin
        quad_pos -= det;
        up = 1'b1;
      end else if (quad_pos <= -det) begin
        quad_pos += det;
        dn = 1'b1;
      end
    end

    if (!list_nav) begin
      // value entry runs opposite to the turn and clamps every sample
      if (up) v -= stp;
      if (dn) v += stp;
      touched = up || dn;
      if (v < lo) begin
        v = lo;
        touched = 1'b1;
      end
      if (v > hi) begin
        v = hi;
        touched = 1'b1;
      end
    end else begin
      if (up) v += 1;
      if (dn) v -= 1;
      if (up || dn || pulse) begin
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        touched = 1'b1;
      end
    end
    knob_value = v[VALUE_WIDTH_DEF-1:0];

    res.value   = knob_value;
    res.changed = touched;
    res.select  = pulse;
    res.held    = btn_state;
  endtask

  task automatic flag_mismatch(input string what);
    $display("%0t: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    knob_out_t want;
    if (rst) begin
      clear_knob();
      knob_q.delete();
    end else begin
      if (cfg_write) take_write(cfg_index, cfg_data);
      if (results.valid && results.ready) begin
        if (knob_q.size() == 0) begin
          flag_mismatch($sformatf("result with nothing expected, value %0d",
                                  results.current_value));
        end else begin
          want = knob_q.pop_front();
          if (results.current_value !== want.value)
            flag_mismatch($sformatf("current_value %0d, expected %0d",
                                    results.current_value, want.value));
          if (results.changed !== want.changed)
            flag_mismatch($sformatf("changed %b, expected %b",
                                    results.changed, want.changed));
          if (results.select_pulse !== want.select)
            flag_mismatch($sformatf("select_pulse %b, expected %b",
                                    results.select_pulse, want.select));
          if (results.button_down !== want.held)
            flag_mismatch($sformatf("button_down %b, expected %b",
                                    results.button_down, want.held));
        end
      end
      if (samples.valid && samples.ready) begin
        knob_sample(samples.pin_a, samples.pin_b, samples.button_raw, want);
        knob_q.push_back(want);
      end
    end
    queued = knob_q.size();
  end

endmodule

### dv/rotary_encoder_value_entry_core_tb.sv
`timescale 1ns / 100ps

module rotary_encoder_value_entry_core_tb;
  import rotenc_pkg::*;

  // far above the slowest legal run, long debounce phase included
  localparam int CYCLE_LIMIT = 200000;
  localparam int NUM_PHASES  = 12;

  // directed pin walk touching every from/to pair, value mode
  localparam logic [1:0] WALK_A [17] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3,
                                         2'd0, 2'd2, 2'd0, 2'd3, 2'd1, 2'd3, 2'd2, 2'd1,
                                         2'd0};
  localparam logic       PRESS_A [17] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1,
                                         1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1,
                                         1'b1};
  // list mode walk: two detents up, two detents down, presses between
  localparam logic [1:0] WALK_B [8]  = '{2'd3, 2'd0, 2'd3, 2'd0, 2'd2, 2'd1, 2'd2, 2'd1};
  localparam logic       PRESS_B [8] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  rotenc_sample_if samples ();
  rotenc_result_if results ();

  int fail_count;
  int pending_count;
  int cycle_count = 0;

  // idle pressure, percent of cycles
  int sender_idle_pct = 0;
  int stall_pct       = 0;

  // encoder and button generator state
  logic [1:0] pins_now;
  logic       turn_up;
  int         pin_hold;
  int         flip_pct;
  int         noise_pct;
  int         hold_max;
  logic       btn_now;
  int         btn_left;
  int         deb_now;
  int         p;
  int         span;

  rotary_encoder_value_entry_core uut (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples),
    .results  (results),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // watches both channels and the register port, predicts every result
  rotary_encoder_value_entry_check chk (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .results   (results),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .waiting   (pending_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // hard stop if the pipeline hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: random back-pressure at the current stall rate
  initial begin
    results.ready = 1'b0;
    forever begin
      @(negedge clk);
      results.ready <= !rst && ($urandom_range(99) >= stall_pct);
    end
  end

  // one sample item: optional idle gap, then hold valid until it is taken
  // entered and left at a falling edge; valid stays high into the next item
  task automatic send_sample(input logic a, input logic b, input logic raw);
    if ($urandom_range(99) < sender_idle_pct) begin
      samples.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    samples.valid      <= 1'b1;
    samples.pin_a      <= a;
    samples.pin_b      <= b;
    samples.button_raw <= raw;
    do @(posedge clk); while (!samples.ready);
    @(negedge clk);
  endtask

  // stop sending and let every expected result drain, plus the pipe depth
  task automatic settle();
    samples.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // full register set; start value goes last since it reloads the value
  task automatic load_setup(input logic lm, input int lo, input int hi, input int stp,
                            input int start, input int det, input int deb,
                            input logic lvl);
    settle();
    set_register(CFG_LIST_MODE, {15'd0, lm});
    set_register(CFG_VALUE_LOW, 16'(lo));
    set_register(CFG_VALUE_HIGH, 16'(hi));
    set_register(CFG_VALUE_STEP, 16'(stp));
    set_register(CFG_DETENT_COUNT, 16'(det));
    set_register(CFG_DEBOUNCE_MS, 16'(deb));
    set_register(CFG_BUTTON_LEVEL, {15'd0, lvl});
    set_register(CFG_START_VALUE, 16'(start));
    deb_now  = deb;
    // next button run goes to the pressed level
    btn_now  = !lvl;
    btn_left = 0;
  endtask

  // next pin pair one count in the given direction
  function automatic logic [1:0] turn_pair(input logic [1:0] ab, input logic up);
    if (up) return (ab[1] == ab[0]) ? ~ab : {ab[0], ab[0]};
    return (ab[1] == ab[0]) ? {~ab[1], ab[0]} : {ab[0], ab[1]};
  endfunction

  // mostly clean turning with holds, some random pin noise
  task automatic next_encoder();
    if (pin_hold > 0) begin
      pin_hold--;
    end else begin
      if ($urandom_range(99) >= noise_pct) begin
        if ($urandom_range(99) < flip_pct) turn_up = !turn_up;
        pins_now = turn_pair(pins_now, turn_up);
      end else begin
        pins_now = 2'($urandom_range(3));
      end
      pin_hold = $urandom_range(hold_max);
    end
  endtask

  // button runs around the debounce time, short bounces when it is small
  task automatic next_button();
    if (btn_left > 0) begin
      btn_left--;
    end else begin
      btn_now = !btn_now;
      if (deb_now < 100 && $urandom_range(3) == 0) btn_left = $urandom_range(1);
      else btn_left = deb_now + $urandom_range(5, deb_now > 100 ? 1 : 0);
    end
  endtask

  initial begin
    rst                = 1'b1;
    samples.valid      = 1'b0;
    samples.pin_a      = 1'b0;
    samples.pin_b      = 1'b0;
    samples.button_raw = 1'b0;
    cfg_write          = 1'b0;
    cfg_index          = CFG_LIST_MODE;
    cfg_data           = '0;
    pins_now           = 2'b00;
    turn_up            = 1'b1;
    pin_hold           = 0;
    btn_now            = 1'b0;
    btn_left           = 0;
    deb_now            = 50;
    flip_pct           = 12;
    noise_pct          = 20;
    hold_max           = 2;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // value mode, start above the top, single count detents, instant debounce
    load_setup(1'b0, -100, 100, 7, 200, 1, 0, 1'b1);
    for (int i = 0; i < 17; i++) begin
      pins_now = WALK_A[i];
      send_sample(pins_now[1], pins_now[0], PRESS_A[i]);
    end

    // list mode with low above high and start below both
    load_setup(1'b1, 5, 3, 0, -9, 2, 0, 1'b0);
    for (int i = 0; i < 8; i++) begin
      pins_now = WALK_B[i];
      send_sample(pins_now[1], pins_now[0], PRESS_B[i]);
    end

    // random phases, each with its own register set and idle pattern
    for (p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin
          sender_idle_pct = 0;
          stall_pct       = 0;
        end
        1: begin
          sender_idle_pct = 52;
          stall_pct       = 0;
        end
        2: begin
          sender_idle_pct = 0;
          stall_pct       = 52;
        end
        default: begin
          sender_idle_pct = 36;
          stall_pct       = 36;
        end
      endcase
      flip_pct  = 12;
      noise_pct = 20;
      hold_max  = 2;
      span      = 65;
      case (p)
        // full range, largest step, start at the top
        0: load_setup(1'b0, -32768, 32767, 1023, 32767, 1, 0, 1'b0);
        // list at the bottom edge, longest detent: steady turning to reach it
        1: begin
          load_setup(1'b1, -32768, 32767, 0, -32768, 63, 3, 1'b1);
          flip_pct  = 0;
          noise_pct = 0;
          hold_max  = 0;
          span      = 140;
        end
        // value mode with low above high, detents off
        2: load_setup(1'b0, 40, -40, 5, 0, 0, 2, 1'b0);
        // longest debounce, one held press
        3: begin
          load_setup(1'($urandom_range(1)), -50, 50, 3, 0, 4, 1023, 1'b1);
          span = 1060;
        end
        // list start out of range, only a press can clamp it
        4: load_setup(1'b1, -20, 10, 1, 100, 0, 1, 1'b0);
        default: begin : random_setup
          int lo;
          lo = $urandom_range(80) - 40;
          load_setup(1'($urandom_range(1)), lo, lo + $urandom_range(60) - 5,
                     ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(6),
                     lo + $urandom_range(80) - 20,
                     ($urandom_range(5) == 0) ? $urandom_range(63) : $urandom_range(4, 1),
                     $urandom_range(6), 1'($urandom_range(1)));
        end
      endcase
      repeat (span) begin
        next_encoder();
        next_button();
        send_sample(pins_now[1], pins_now[0], btn_now);
      end
    end

    // drain and let the pipe empty before the verdict
    samples.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
